[hdl/lcc_pkg.sv]
// Shared widths, types and helpers for the line clipper.
// Used by every module of line_clip_to_canvas; depends on nothing.
package lcc_pkg;

  // Coordinate width of the input endpoints
  localparam int COORD_BITS = 16;
  localparam int CW  = COORD_BITS;
  // Register and output coordinate width
  localparam int RW  = 13;
  // Signed endpoint difference and its magnitude
  localparam int DW  = CW + 1;
  localparam int MW  = CW + 1;
  // Signed width holding a coordinate and a coordinate minus a register
  localparam int EW  = ((CW > 14) ? CW : 14) + 1;
  // First move: offset, product, saturated quotient, moved y
  localparam int OW1 = CW;
  localparam int P1W = OW1 + MW;
  localparam int QS1 = (P1W > 63) ? 63 : P1W;
  localparam int Y1W = QS1 + 2;
  // Second move: offset, product, saturated quotient, moved x
  localparam int OW2 = QS1 + 2;
  localparam int P2W = OW2 + MW;
  localparam int QS2 = (P2W > 63) ? 63 : P2W;
  localparam int X2W = QS2 + 2;
  // Register stages in one endpoint pipe
  localparam int PL  = P1W + P2W + 5;

  // Stream widths, padded to whole bytes
  localparam int IN_TW  = ((4 * CW + 7) / 8) * 8;
  localparam int OUT_TW = ((4 * RW + 7) / 8) * 8;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Register port
  localparam int AW = 3;
  localparam logic [RW-1:0] WIDTH_RST  = 13'd640;
  localparam logic [RW-1:0] HEIGHT_RST = 13'd480;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_VERT,
    KIND_HORZ,
    KIND_GEN
  } kind_t;

  typedef struct packed {
    logic          ok;
    logic [RW-1:0] sx;
    logic [RW-1:0] sy;
    logic [RW-1:0] ex;
    logic [RW-1:0] ey;
  } res_t;

  // One endpoint with the segment's slope data
  typedef struct packed {
    coord_t        x;
    coord_t        y;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
    logic          slope_neg;
  } pt_in_t;

  typedef struct packed {
    kind_t kind;
    res_t  early;
  } side_t;

  typedef struct packed {
    pt_in_t p0;
    pt_in_t p1;
    side_t  side;
  } entry_t;

  typedef struct packed {
    logic          ok;
    logic [RW-1:0] x;
    logic [RW-1:0] y;
  } pt_out_t;

  // v within [0, hi]
  function automatic logic in_box(coord_t v, logic [RW-1:0] hi);
    logic signed [EW-1:0] ve;
    logic signed [EW-1:0] he;
    ve = EW'(v);
    he = $signed(EW'({1'b0, hi}));
    return (ve >= 0) && (ve <= he);
  endfunction

  // v clamped to [0, hi]
  function automatic logic [RW-1:0] clamp_coord(coord_t v, logic [RW-1:0] hi);
    logic signed [EW-1:0] ve;
    logic signed [EW-1:0] he;
    ve = EW'(v);
    he = $signed(EW'({1'b0, hi}));
    if (ve < 0) begin
      return '0;
    end else if (ve > he) begin
      return hi;
    end
    return RW'(v);
  endfunction

endpackage

[hdl/lcc_front.sv]
// Front end: unpacks an input item, classifies the segment and works out
// the easy cases. Depends on lcc_pkg.
module lcc_front import lcc_pkg::*; (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_TW-1:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic [RW-1:0]    clip_width,
  input  logic [RW-1:0]    clip_height,
  input  logic             fifo_full,
  output logic             push,
  output entry_t           entry
);

  coord_t bx, by, ex, ey;
  logic signed [DW-1:0] dx, dy;
  logic [MW-1:0] adx, ady;
  logic slope_neg;
  kind_t kind;
  res_t early;

  assign bx = s_axis_tdata[CW-1:0];
  assign by = s_axis_tdata[2*CW-1:CW];
  assign ex = s_axis_tdata[3*CW-1:2*CW];
  assign ey = s_axis_tdata[4*CW-1:3*CW];

  // handshake: take an item whenever the queue has room
  assign s_axis_tready = !fifo_full;
  assign push = s_axis_tvalid && !fifo_full;

  // deltas and their magnitudes
  assign dx = DW'(ex) - DW'(bx);
  assign dy = DW'(ey) - DW'(by);
  assign adx = MW'(dx[DW-1] ? -dx : dx);
  assign ady = MW'(dy[DW-1] ? -dy : dy);
  assign slope_neg = dx[DW-1] ^ dy[DW-1];

  // classify; a single point counts as vertical
  always_comb begin
    if (dx == '0) begin
      kind = KIND_VERT;
    end else if (dy == '0) begin
      kind = KIND_HORZ;
    end else begin
      kind = KIND_GEN;
    end
  end

  // axis-aligned segments need only a range test and clamps
  always_comb begin
    early = '0;
    case (kind)
      KIND_VERT: begin
        early.ok = in_box(bx, clip_width);
        early.sx = RW'(bx);
        early.sy = clamp_coord(by, clip_height);
        early.ex = RW'(ex);
        early.ey = clamp_coord(ey, clip_height);
      end
      KIND_HORZ: begin
        early.ok = in_box(by, clip_height);
        early.sx = clamp_coord(bx, clip_width);
        early.sy = RW'(by);
        early.ex = clamp_coord(ex, clip_width);
        early.ey = RW'(ey);
      end
      default: begin
        early = '0;
      end
    endcase
    if (!early.ok) begin
      early = '0;
    end
  end

  assign entry.p0 = '{x: bx, y: by, adx: adx, ady: ady, slope_neg: slope_neg};
  assign entry.p1 = '{x: ex, y: ey, adx: adx, ady: ady, slope_neg: slope_neg};
  assign entry.side = '{kind: kind, early: early};

endmodule

[hdl/lcc_fifo.sv]
// Short queue of classified items between front and back.
// Depends on lcc_pkg.
module lcc_fifo import lcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   empty,
  output logic   full
);

  entry_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_entry = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

[hdl/lcc_point.sv]
// Endpoint pipe: moves one endpoint onto the x edge, then the y edge, with
// two restoring divider pipelines (one quotient bit per stage). Uses lcc_pkg.
module lcc_point import lcc_pkg::*; (
  input  logic          clk,
  input  logic          adv,
  input  pt_in_t        pin,
  input  logic [RW-1:0] clip_width,
  input  logic [RW-1:0] clip_height,
  output pt_out_t       pout
);

  localparam int QX1 = (P1W > 63) ? P1W : 63;
  localparam int QX2 = (P2W > 63) ? P2W : 63;
  localparam logic [QX1-1:0] QLIM1 = QX1'(1) << 62;
  localparam logic [QX2-1:0] QLIM2 = QX2'(1) << 62;

  typedef struct packed {
    logic [RW-1:0] x1;
    coord_t        y;
    logic          mv;
    logic          add;
    logic          slope_neg;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
  } c1_t;

  typedef struct packed {
    logic [RW-1:0] x1;
    logic [RW-1:0] y2;
    logic          mv;
    logic          add;
    logic [MW-1:0] ady;
  } c2_t;

  // stage A: x edge test and first offset
  logic signed [EW-1:0] xe, we;
  logic x_lo, x_hi;
  logic [OW1-1:0] a_off;
  c1_t a_c;

  assign xe = EW'(pin.x);
  assign we = $signed(EW'({1'b0, clip_width}));
  assign x_lo = xe < 0;
  assign x_hi = xe > we;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_off <= OW1'(x_lo ? -xe : xe - we);
      a_c.x1 <= x_lo ? '0 : (x_hi ? clip_width : RW'(pin.x));
      a_c.y <= pin.y;
      a_c.mv <= x_lo || x_hi;
      a_c.add <= x_lo ^ pin.slope_neg;
      a_c.slope_neg <= pin.slope_neg;
      a_c.adx <= pin.adx;
      a_c.ady <= pin.ady;
    end
  end

  // first divider: offset*|dy| / |dx|
  logic [MW-1:0]  d1_rem [P1W+1];
  logic [P1W-1:0] d1_nq  [P1W+1];
  c1_t            d1_c   [P1W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem[0] <= '0;
      d1_nq[0] <= {{MW{1'b0}}, a_off} * {{OW1{1'b0}}, a_c.ady};
      d1_c[0] <= a_c;
    end
  end

  for (genvar k = 1; k <= P1W; k++) begin : g_div1
    logic [MW:0] t;
    logic ge;
    assign t = {d1_rem[k-1], d1_nq[k-1][P1W-1]};
    assign ge = t >= {1'b0, d1_c[k-1].adx};
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_rem[k] <= ge ? MW'(t - {1'b0, d1_c[k-1].adx}) : MW'(t);
        d1_nq[k] <= {d1_nq[k-1][P1W-2:0], ge};
        d1_c[k] <= d1_c[k-1];
      end
    end
  end

  // stage C: apply the first move to y
  logic [QX1-1:0] q1x;
  logic [QS1-1:0] q1s;
  logic signed [Y1W-1:0] ye, q1e;
  logic signed [Y1W-1:0] c_y1;
  c1_t c_c;

  assign q1x = QX1'(d1_nq[P1W]);
  assign q1s = QS1'((q1x > QLIM1) ? QLIM1 : q1x);
  assign ye = Y1W'(d1_c[P1W].y);
  assign q1e = $signed({2'b00, q1s});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!d1_c[P1W].mv) begin
        c_y1 <= ye;
      end else if (d1_c[P1W].add) begin
        c_y1 <= ye + q1e;
      end else begin
        c_y1 <= ye - q1e;
      end
      c_c <= d1_c[P1W];
    end
  end

  // stage D: y edge test and second offset
  logic signed [Y1W-1:0] he;
  logic y_lo, y_hi;
  logic [OW2-1:0] d_off;
  logic [MW-1:0] d_adx;
  c2_t d_c;

  assign he = $signed(Y1W'({1'b0, clip_height}));
  assign y_lo = c_y1 < 0;
  assign y_hi = c_y1 > he;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_off <= OW2'(y_lo ? -c_y1 : c_y1 - he);
      d_adx <= c_c.adx;
      d_c.x1 <= c_c.x1;
      d_c.y2 <= y_lo ? '0 : (y_hi ? clip_height : RW'(c_y1));
      d_c.mv <= y_lo || y_hi;
      d_c.add <= y_lo ^ c_c.slope_neg;
      d_c.ady <= c_c.ady;
    end
  end

  // second divider: offset*|dx| / |dy|
  logic [MW-1:0]  d2_rem [P2W+1];
  logic [P2W-1:0] d2_nq  [P2W+1];
  c2_t            d2_c   [P2W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_rem[0] <= '0;
      d2_nq[0] <= {{MW{1'b0}}, d_off} * {{OW2{1'b0}}, d_adx};
      d2_c[0] <= d_c;
    end
  end

  for (genvar k = 1; k <= P2W; k++) begin : g_div2
    logic [MW:0] t;
    logic ge;
    assign t = {d2_rem[k-1], d2_nq[k-1][P2W-1]};
    assign ge = t >= {1'b0, d2_c[k-1].ady};
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_rem[k] <= ge ? MW'(t - {1'b0, d2_c[k-1].ady}) : MW'(t);
        d2_nq[k] <= {d2_nq[k-1][P2W-2:0], ge};
        d2_c[k] <= d2_c[k-1];
      end
    end
  end

  // final: apply the second move to x and test x against the box
  logic [QX2-1:0] q2x;
  logic [QS2-1:0] q2s;
  logic signed [X2W-1:0] x1e, q2e, x2, we2;

  assign q2x = QX2'(d2_nq[P2W]);
  assign q2s = QS2'((q2x > QLIM2) ? QLIM2 : q2x);
  assign x1e = $signed({{(X2W-RW){1'b0}}, d2_c[P2W].x1});
  assign q2e = $signed({2'b00, q2s});
  assign we2 = $signed({{(X2W-RW){1'b0}}, clip_width});

  always_comb begin
    if (!d2_c[P2W].mv) begin
      x2 = x1e;
    end else if (d2_c[P2W].add) begin
      x2 = x1e + q2e;
    end else begin
      x2 = x1e - q2e;
    end
  end

  assign pout.ok = (x2 >= 0) && (x2 <= we2);
  assign pout.x = RW'(x2);
  assign pout.y = d2_c[P2W].y2;

endmodule

[hdl/lcc_back.sv]
// Back end: runs both endpoints through their pipes, carries the item's
// class alongside, and holds the result item. Depends on lcc_pkg, lcc_point.
module lcc_back import lcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  entry_t            head,
  input  logic              fifo_empty,
  output logic              pop,
  input  logic [RW-1:0]     clip_width,
  input  logic [RW-1:0]     clip_height,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,  // clipped sx, sy, ex, ey, zero pad
  output logic              m_axis_tuser   // accepted
);

  logic adv;
  logic v [PL];
  side_t sd [PL];
  pt_out_t o0, o1;
  res_t res;

  // whole pipe moves when the output register is free or being taken
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign pop = adv && !fifo_empty;

  lcc_point u_p0 (
    .clk(clk), .adv(adv), .pin(head.p0),
    .clip_width(clip_width), .clip_height(clip_height), .pout(o0)
  );

  lcc_point u_p1 (
    .clk(clk), .adv(adv), .pin(head.p1),
    .clip_width(clip_width), .clip_height(clip_height), .pout(o1)
  );

  // valid line and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PL; i++) begin
        v[i] <= 1'b0;
      end
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v[0] <= !fifo_empty;
      for (int i = 1; i < PL; i++) begin
        v[i] <= v[i-1];
      end
      m_axis_tvalid <= v[PL-1];
    end
  end

  // item class travels beside the endpoint pipes
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= head.side;
      for (int i = 1; i < PL; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // pick the result; a rejected item gives zeros
  always_comb begin
    case (sd[PL-1].kind)
      KIND_GEN: begin
        res = '{ok: 1'b1, sx: o0.x, sy: o0.y, ex: o1.x, ey: o1.y};
        if (!(o0.ok && o1.ok)) begin
          res = '0;
        end
      end
      default: begin
        res = sd[PL-1].early;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= res.ok;
      m_axis_tdata <= {{(OUT_TW-4*RW){1'b0}}, res.ey, res.ex, res.sy, res.sx};
    end
  end

endmodule

[hdl/line_clip_to_canvas.sv]
// Top level of the line clipper: register port, front, queue and back.
// Depends on lcc_pkg, lcc_front, lcc_fifo, lcc_back.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: start_x, start_y, end_x, end_y
//  m_axis    out        m_axis_tvalid/tready    tdata: sx, sy, ex, ey; tuser: accepted
//  apb       in/out     psel/penable/pready     0x0 clip_width, 0x4 clip_height
//
// One item per cycle sustained while m_axis is ready; each item passes the queue, the
// endpoint pipes with their two restoring divider pipelines, and the output register.
// Synchronous reset empties queue and pipes and loads 640 x 480.
// A stall on m_axis freezes the pipes; s_axis keeps taking items until the
// four-entry queue fills.
module line_clip_to_canvas import lcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,   // clipped sx, sy, ex, ey, zero pad
  output logic              m_axis_tuser,   // accepted
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AW-1:0]     paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [RW-1:0] clip_width, clip_height;
  logic push, pop, fifo_full, fifo_empty;
  entry_t wr_entry, head;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_width  <= WIDTH_RST;
      clip_height <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WIDTH:  clip_width  <= pwdata[RW-1:0];
        REG_HEIGHT: clip_height <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(32-RW){1'b0}}, clip_width};
      REG_HEIGHT: prdata = {{(32-RW){1'b0}}, clip_height};
      default:    prdata = '0;
    endcase
  end

  lcc_front u_front (
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .clip_width(clip_width),
    .clip_height(clip_height), .fifo_full(fifo_full), .push(push),
    .entry(wr_entry)
  );

  lcc_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_entry(wr_entry), .pop(pop),
    .rd_entry(head), .empty(fifo_empty), .full(fifo_full)
  );

  lcc_back u_back (
    .clk(clk), .rst(rst), .head(head), .fifo_empty(fifo_empty), .pop(pop),
    .clip_width(clip_width), .clip_height(clip_height),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

[hdl/lcc_checker.sv]
// Port-level checks for line_clip_to_canvas, attached by bind.
// Depends on lcc_pkg and the top level's ports.
module lcc_checker import lcc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TW-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AW-1:0]     paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a rejected segment carries zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected item with non-zero coordinates");

  // a register reads back what was just written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(psel && penable && pwrite && pready) && psel && !pwrite
      && paddr == $past(paddr) |-> prdata == {19'b0, $past(pwdata[12:0])})
    else $error("register read-back mismatch");

endmodule

bind line_clip_to_canvas lcc_checker u_lcc_checker (.*);

[verif/line_clip_to_canvas_test.sv]
// Self-checking testbench for line_clip_to_canvas: random and directed segments,
// register writes over the APB port, output checked against an in-bench predictor.
// Depends on lcc_pkg and the line_clip_to_canvas RTL.
module line_clip_to_canvas_test;
  import lcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic          vis;
    logic [RW-1:0] sx;
    logic [RW-1:0] sy;
    logic [RW-1:0] ex;
    logic [RW-1:0] ey;
  } clip_res_t;

  // Clip predictor and store of expected clipped segments
  class clip_board;
    longint    box_w = 640;
    longint    box_h = 480;
    clip_res_t pending[$];
    int        errors = 0;

    // trunc(a*b/c); operands stay small enough for 64-bit products here
    function longint scale(longint a, longint b, longint c);
      longint p;
      p = a * b;
      return p / c;
    endfunction

    function bit slide(inout longint x, inout longint y, input longint dx, dy);
      if (x < 0) begin
        y = y - scale(x, dy, dx);
        x = 0;
      end else if (x > box_w) begin
        y = y + scale(box_w - x, dy, dx);
        x = box_w;
      end
      if (y < 0) begin
        x = x - scale(y, dx, dy);
        y = 0;
      end else if (y > box_h) begin
        x = x + scale(box_h - y, dx, dy);
        y = box_h;
      end
      return x >= 0 && x <= box_w;
    endfunction

    function longint limit(longint v, longint hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function void note_segment(logic [IN_TW-1:0] d);
      longint bx, by, ex, ey, dx, dy;
      bit vis;
      clip_res_t r;
      bx = longint'($signed(d[15:0]));
      by = longint'($signed(d[31:16]));
      ex = longint'($signed(d[47:32]));
      ey = longint'($signed(d[63:48]));
      dx = ex - bx;
      dy = ey - by;
      if (dx == 0) begin
        vis = bx >= 0 && bx <= box_w;
        by = limit(by, box_h);
        ey = limit(ey, box_h);
      end else if (dy == 0) begin
        vis = by >= 0 && by <= box_h;
        bx = limit(bx, box_w);
        ex = limit(ex, box_w);
      end else begin
        vis = slide(bx, by, dx, dy);
        if (vis) vis = slide(ex, ey, dx, dy);
      end
      r.vis = vis;
      r.sx = vis ? RW'(bx) : '0;
      r.sy = vis ? RW'(by) : '0;
      r.ex = vis ? RW'(ex) : '0;
      r.ey = vis ? RW'(ey) : '0;
      pending.push_back(r);
    endfunction

    function void check_segment(logic [OUT_TW-1:0] d, logic vis);
      clip_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vis !== e.vis) begin
        $error("accepted: expected %0d actual %0d", e.vis, vis); errors++;
      end
      if (d[12:0] !== e.sx) begin
        $error("clipped_start_x: expected %0d actual %0d", e.sx, d[12:0]); errors++;
      end
      if (d[25:13] !== e.sy) begin
        $error("clipped_start_y: expected %0d actual %0d", e.sy, d[25:13]); errors++;
      end
      if (d[38:26] !== e.ex) begin
        $error("clipped_end_x: expected %0d actual %0d", e.ex, d[38:26]); errors++;
      end
      if (d[51:39] !== e.ey) begin
        $error("clipped_end_y: expected %0d actual %0d", e.ey, d[51:39]); errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN    = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic              m_axis_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AW-1:0]     paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  clip_board board = new();
  bit        calm = 1'b0;      // no idling on either side
  bit        hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit        hold_done = 1'b0; // hold-off already started
  int        hold_off = 0;     // receiver hold-off cycles still to run
  int        quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_clip_to_canvas u_top (.*);

  // Receiver: random stalls, plus long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_segment(m_axis_tdata, m_axis_tuser);
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("line_clip_to_canvas: mismatch");
      $finish;
    end
  end

  task automatic reg_write(input logic [AW-1:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) board.box_w = val & 32'h1FFF;
    else board.box_h = val & 32'h1FFF;
  endtask

  task automatic send_segment(input logic [15:0] sx, sy, ex, ey);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sx, sy, ex, ey} == 0 ? '0 : IN_TW'({ey, ex, sy, sx});
    do @(posedge clk); while (!s_axis_tready);
    board.note_segment(s_axis_tdata);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Coordinates mostly near the box, some anywhere in range
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: return 16'($signed(-$urandom_range(50)));
      default: return 16'($urandom_range(700));
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [15:0] a, b, c, d;
    for (int i = 0; i < n; i++) begin
      a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
      case ($urandom_range(9))
        0: c = a;       // vertical
        1: d = b;       // horizontal
        default: ;
      endcase
      send_segment(a, b, c, d);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, vertical, horizontal, single point, rejections
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_segment(16'd100, 16'h8000, 16'd100, 16'h7FFF);
    send_segment(16'd700, 16'd5, 16'd700, 16'd50);
    send_segment(16'h8000, 16'd20, 16'h7FFF, 16'd20);
    send_segment(16'd10, 16'd500, 16'd600, 16'd500);
    send_segment(16'd33, 16'd44, 16'd33, 16'd44);
    send_segment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_segment(16'hFFF6, 16'd10, 16'd650, 16'd470);
    send_segment(16'd1000, 16'd0, 16'd2000, 16'd10);
    send_segment(16'd0, 16'd0, 16'd640, 16'd480);
    send_segment(16'd700, 16'hFFEC, 16'hFFEC, 16'd600);
    send_segment(16'd600, 16'd100, 16'd900, 16'd9000);
    drain();

    // Zero-sized box, then largest width with a height of 4096
    reg_write(3'd0, 32'd0);
    reg_write(3'd4, 32'd0);
    send_segment(16'd0, 16'd0, 16'd0, 16'd5);
    send_segment(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
    random_phase(40);
    drain();
    reg_write(3'd0, 32'hFFFF_FFFF);
    reg_write(3'd4, 32'hFFFF_E000 | 32'd4096);
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    random_phase(150);
    drain();

    // Reset sizes, with a long receiver hold-off to fill the queue
    reg_write(3'd0, 32'd640);
    reg_write(3'd4, 32'd480);
    hold_req = 1'b1;
    random_phase(300);
    drain();

    // Random box, no idling stretch
    reg_write(3'd0, $urandom_range(4096));
    reg_write(3'd4, $urandom_range(4096));
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;
    drain();

    reg_write(3'd0, 32'd4096);
    reg_write(3'd4, 32'd1);
    random_phase(340);
    drain();

    if (board.errors == 0)
      $display("line_clip_to_canvas: match");
    else
      $display("line_clip_to_canvas: mismatch");
    $finish;
  end
endmodule

[files.f]
hdl/lcc_pkg.sv
hdl/lcc_front.sv
hdl/lcc_fifo.sv
hdl/lcc_point.sv
hdl/lcc_back.sv
hdl/line_clip_to_canvas.sv
hdl/lcc_checker.sv
verif/line_clip_to_canvas_test.sv
